// File: rtl/extended_shift_and_matcher_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the extended shift-and matcher
// Concurrent checks clocked on clk; compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef EXTENDED_SHIFT_AND_MATCHER_UNIT_MACROS_SVH
`define EXTENDED_SHIFT_AND_MATCHER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// check a property outside reset
`define ESAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// check a property in every cycle, reset included
`define ESAM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ESAM_ASSERT(lbl, prop, msg)
`define ESAM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/esam_pkg.sv
// ----------------------------------------------------------------------------
// esam_pkg
// Shared types, codes and defaults of the extended shift-and matcher.
// ----------------------------------------------------------------------------
package esam_pkg;

  localparam int PATTERN_WIDTH_DEF = 64;
  localparam int ALPHABET_SIZE_DEF = 256;

  localparam int SYM_W  = 8;
  localparam int MASK_W = 64;
  localparam int POS_W  = 32;
  localparam int CFG_W  = 2;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_TEXT    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [CFG_W-1:0] {
    CFG_OPTIONAL  = 2'd0,
    CFG_GAP_BEGIN = 2'd1,
    CFG_GAP_END   = 2'd2,
    CFG_ACCEPT    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [SYM_W-1:0] symbol;
  } tbl_req_t;

endpackage

// File: rtl/esam_table.sv
// ----------------------------------------------------------------------------
// esam_table
// Per-symbol match and repeat mask memory, registered read.
// Entries never written read as zero through per-entry fill bits.
// ----------------------------------------------------------------------------
module esam_table
  import esam_pkg::*;
#(
  parameter int PATTERN_WIDTH = PATTERN_WIDTH_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tbl_req_t                 req,
  input  logic [PATTERN_WIDTH-1:0] wr_match,
  input  logic [PATTERN_WIDTH-1:0] wr_repeat,
  output logic [PATTERN_WIDTH-1:0] rd_match,
  output logic [PATTERN_WIDTH-1:0] rd_repeat
);

  localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

  logic [2*PATTERN_WIDTH-1:0] mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0]   filled;
  logic [2*PATTERN_WIDTH-1:0] rdata;
  logic                       hit;
  logic                       in_range;
  logic [AW-1:0]              addr;

  assign in_range = {1'b0, req.symbol} < (SYM_W + 1)'(ALPHABET_SIZE);
  assign addr     = req.symbol[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.wr_en && in_range) begin
      mem[addr] <= {wr_repeat, wr_match};
    end
    if (req.rd_en) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      hit    <= 1'b0;
    end else begin
      if (req.wr_en && in_range) begin
        filled[addr] <= 1'b1;
      end
      if (req.rd_en) begin
        hit <= in_range && filled[addr];
      end
    end
  end

  assign rd_match  = hit ? rdata[PATTERN_WIDTH-1:0] : '0;
  assign rd_repeat = hit ? rdata[2*PATTERN_WIDTH-1:PATTERN_WIDTH] : '0;

endmodule

// File: rtl/extended_shift_and_matcher_unit.sv
// A text beat's table read is registered, then its result on the outputs.
// Throughput: one beat per cycle unless the output stalls; the table read and
// vector update pipeline over two stages, the vector loop closing each beat.
// Load, restart and unused opcodes produce no result.
// Reset clears the configuration masks, vector, position and table fill bits
// at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// extended_shift_and_matcher_unit
// Bit-parallel shift-and matcher with optional, repeated and starred
// positions, fed one opcode beat per cycle unless the output stalls.
// ----------------------------------------------------------------------------
`include "extended_shift_and_matcher_unit_macros.svh"

module extended_shift_and_matcher_unit
  import esam_pkg::*;
#(
  parameter int PATTERN_WIDTH = PATTERN_WIDTH_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic [SYM_W-1:0]  symbol,
  input  logic [MASK_W-1:0] match_mask,
  input  logic [MASK_W-1:0] repeat_mask,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              match_found,
  output logic [POS_W-1:0]  end_position,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_index,
  input  logic [MASK_W-1:0] cfg_data
);

  localparam int PW = PATTERN_WIDTH;

  logic [PW-1:0]    optional_positions;
  logic [PW-1:0]    gap_begin_mask;
  logic [PW-1:0]    gap_end_mask;
  logic [PW-1:0]    accept_mask;

  logic [PW-1:0]    active;
  logic [PW-1:0]    active_next;
  logic [POS_W-1:0] text_pos;

  logic             s1_valid;
  op_t              s1_op;
  logic             s1_go;
  logic             in_fire;
  op_t              in_op;

  tbl_req_t         req;
  logic [PW-1:0]    cm;
  logic [PW-1:0]    rm;
  logic [PW-1:0]    d_step;
  logic [PW-1:0]    t_vec;
  logic [PW-1:0]    closure;
  logic             found;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      optional_positions <= '0;
      gap_begin_mask     <= '0;
      gap_end_mask       <= '0;
      accept_mask        <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_OPTIONAL:  optional_positions <= cfg_data[PW-1:0];
        CFG_GAP_BEGIN: gap_begin_mask     <= cfg_data[PW-1:0];
        CFG_GAP_END:   gap_end_mask       <= cfg_data[PW-1:0];
        CFG_ACCEPT:    accept_mask        <= cfg_data[PW-1:0];
      endcase
    end
  end

  assign in_op    = op_t'(opcode);
  assign s1_go    = s1_valid && ((s1_op != OP_TEXT) || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;
  assign in_fire  = in_valid && in_ready;

  assign req.wr_en  = in_fire && (in_op == OP_LOAD);
  assign req.rd_en  = in_fire && (in_op == OP_TEXT);
  assign req.symbol = symbol;

  esam_table #(
    .PATTERN_WIDTH(PATTERN_WIDTH),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .wr_match (match_mask[PW-1:0]),
    .wr_repeat(repeat_mask[PW-1:0]),
    .rd_match (cm),
    .rd_repeat(rm)
  );

  always_comb begin
    d_step      = (((active << 1) | PW'(1)) & cm) | (active & rm);
    t_vec       = d_step | gap_end_mask;
    closure     = ~(t_vec - gap_begin_mask) ^ t_vec;
    active_next = d_step | (optional_positions & closure);
    found       = |(active_next & accept_mask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_op    <= OP_NONE;
    end else if (in_ready) begin
      s1_valid <= in_fire && ((in_op == OP_TEXT) || (in_op == OP_RESTART));
      s1_op    <= in_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= '0;
      text_pos <= '0;
    end else if (s1_go) begin
      unique case (s1_op)
        OP_TEXT: begin
          active <= active_next;
          if (text_pos != '1) begin
            text_pos <= text_pos + POS_W'(1);
          end
        end
        OP_RESTART: begin
          active   <= '0;
          text_pos <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && (s1_op == OP_TEXT)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (s1_op == OP_TEXT)) begin
      match_found  <= found;
      end_position <= text_pos;
    end
  end

  `ESAM_ASSERT(a_text_gives_beat, (s1_go && (s1_op == OP_TEXT)) |=> out_valid, "text beat lost")
  `ESAM_ASSERT(a_restart_clears, (s1_go && (s1_op == OP_RESTART)) |=> ((text_pos == '0) && (active == '0)), "restart did not clear")
  `ESAM_ASSERT(a_pos_monotone, !(s1_go && (s1_op == OP_RESTART)) |=> (text_pos >= $past(text_pos)), "position went back")
  `ESAM_ASSERT_ALWAYS(a_one_table_access, !(req.wr_en && req.rd_en), "table read and write together")

endmodule

// File: tb/extended_shift_and_matcher_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_shift_and_matcher_unit_tb
// Drives load, text, restart and unused opcode beats into the matcher
// under random sender bursts and receiver stalls. A scoreboard predicts the
// match report of every text beat and checks each report field by field.
// ----------------------------------------------------------------------------
module extended_shift_and_matcher_unit_tb;
  import esam_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_BEATS = 800;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } match_report_t;

  class match_scoreboard;
    logic [MASK_W-1:0] match_tbl [ALPHABET_SIZE_DEF];
    logic [MASK_W-1:0] repeat_tbl [ALPHABET_SIZE_DEF];
    logic [MASK_W-1:0] optional_pos, gap_begin, gap_end, accept;
    logic [MASK_W-1:0] active;
    logic [POS_W-1:0]  text_pos;
    match_report_t     expected_reports [$];
    int                mismatches;

    function new();
      for (int k = 0; k < ALPHABET_SIZE_DEF; k++) begin
        match_tbl[k]  = '0;
        repeat_tbl[k] = '0;
      end
      optional_pos = '0;
      gap_begin    = '0;
      gap_end      = '0;
      accept       = '0;
      active       = '0;
      text_pos     = '0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [CFG_W-1:0] idx, logic [MASK_W-1:0] data);
      case (cfg_reg_t'(idx))
        CFG_OPTIONAL:  optional_pos = data;
        CFG_GAP_BEGIN: gap_begin    = data;
        CFG_GAP_END:   gap_end      = data;
        CFG_ACCEPT:    accept       = data;
        default: ;
      endcase
    endfunction

    function void note_beat(logic [1:0] op, logic [SYM_W-1:0] sym,
                            logic [MASK_W-1:0] mm, logic [MASK_W-1:0] rm);
      logic [MASK_W-1:0] d, t, closure;
      match_report_t rep;
      case (op_t'(op))
        OP_LOAD: begin
          match_tbl[sym]  = mm;
          repeat_tbl[sym] = rm;
        end
        OP_RESTART: begin
          active   = '0;
          text_pos = '0;
        end
        OP_TEXT: begin
          d = (((active << 1) | 64'd1) & match_tbl[sym]) | (active & repeat_tbl[sym]);
          t = d | gap_end;
          closure = ~(t - gap_begin) ^ t;
          d = d | (optional_pos & closure);
          active = d;
          rep.found    = |(d & accept);
          rep.position = text_pos;
          expected_reports.push_back(rep);
          if (text_pos != '1) text_pos = text_pos + 1'b1;
        end
        default: ;
      endcase
    endfunction

    function void check_report(logic found, logic [POS_W-1:0] position);
      match_report_t want;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected report: match_found=%0b end_position=%0d", found, position);
        return;
      end
      want = expected_reports.pop_front();
      if (want.found !== found || want.position !== position) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report mismatch: expected match_found=%0b end_position=%0d, got %0b %0d",
                   want.found, want.position, found, position);
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        opcode = OP_NONE;
  logic [SYM_W-1:0]  symbol = '0;
  logic [MASK_W-1:0] match_mask = '0;
  logic [MASK_W-1:0] repeat_mask = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              match_found;
  logic [POS_W-1:0]  end_position;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_index = CFG_OPTIONAL;
  logic [MASK_W-1:0] cfg_data = '0;

  extended_shift_and_matcher_unit dut (.*);

  match_scoreboard sb = new();

  int burst_left = 0;
  bit steady = 1'b0;
  int sent_beats = 0;
  int idle_cycles = 0;

  int               pat_len;
  int               pat_idx [64];
  bit               pat_opt [64];
  bit               pat_rep [64];
  logic [SYM_W-1:0] alpha [4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_beat(opcode, symbol, match_mask, repeat_mask);
    if (!rst && out_valid && out_ready) sb.check_report(match_found, end_position);
    if (!rst && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("extended_shift_and_matcher_unit_tb: errors");
    $finish;
  end

  // receiver: stretches of always-ready, random and periodic stalls
  initial begin
    int mode, len, period;
    forever begin
      mode   = $urandom_range(0, 2);
      len    = $urandom_range(5, 60);
      period = $urandom_range(2, 5);
      for (int k = 0; k < len; k++) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (k % period) != 0;
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic logic [MASK_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [SYM_W-1:0] rand_sym();
    return SYM_W'($urandom_range(0, 255));
  endfunction

  task automatic send_beat(op_t op, logic [SYM_W-1:0] sym,
                           logic [MASK_W-1:0] mm = '0, logic [MASK_W-1:0] rm = '0);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    opcode      <= op;
    symbol      <= sym;
    match_mask  <= mm;
    repeat_mask <= rm;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (op != OP_NONE) sent_beats++;
  endtask

  task automatic load_registers(logic [MASK_W-1:0] opt, logic [MASK_W-1:0] gb,
                                logic [MASK_W-1:0] ge, logic [MASK_W-1:0] acc);
    logic [MASK_W-1:0] vals [4];
    vals = '{opt, gb, ge, acc};
    for (int i = 0; i < 4; i++) begin
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= vals[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // hold input idle until every report is back, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic emit_instance();
    int n;
    for (int i = 0; i < pat_len; i++) begin
      if (pat_opt[i] && $urandom_range(0, 1)) continue;
      n = pat_rep[i] ? $urandom_range(1, 3) : 1;
      repeat (n) send_beat(OP_TEXT, alpha[pat_idx[i]]);
    end
  endtask

  initial begin
    logic [MASK_W-1:0] opt, gb, ge, acc, mm, rm;
    int directed_beats, kind, phase_len, phase_start, r;

    @(posedge clk);
    while (rst) @(posedge clk);

    send_beat(OP_TEXT, 8'h00);
    send_beat(OP_TEXT, 8'hFF);
    send_beat(OP_NONE, 8'h00, '1, '1);
    send_beat(OP_TEXT, 8'h00);
    send_beat(OP_LOAD, 8'h00, '1, '1);
    send_beat(OP_LOAD, 8'hFF, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_beat(OP_TEXT, 8'h00);
    send_beat(OP_TEXT, 8'h00);
    send_beat(OP_TEXT, 8'hFF);
    send_beat(OP_RESTART, 8'h00);
    send_beat(OP_TEXT, 8'h00);
    send_beat(OP_LOAD, 8'h00, '0, '0);
    send_beat(OP_TEXT, 8'h00);
    drain();
    load_registers('1, '1, '1, '1);
    send_beat(OP_TEXT, 8'hFF);
    send_beat(OP_TEXT, 8'h00);
    send_beat(OP_RESTART, 8'hFF);
    send_beat(OP_TEXT, 8'hFF);
    send_beat(OP_NONE, 8'hFF, '0, '0);
    send_beat(OP_TEXT, 8'hFF);
    drain();
    // a b* c: b may be skipped or repeated
    load_registers(64'h2, 64'h1, 64'h2, 64'h4);
    send_beat(OP_LOAD, 8'h61, 64'h1, 64'h0);
    send_beat(OP_LOAD, 8'h62, 64'h2, 64'h2);
    send_beat(OP_LOAD, 8'h63, 64'h4, 64'h0);
    send_beat(OP_RESTART, 8'h00);
    send_beat(OP_TEXT, 8'h61);
    send_beat(OP_TEXT, 8'h63);
    send_beat(OP_TEXT, 8'h61);
    send_beat(OP_TEXT, 8'h62);
    send_beat(OP_TEXT, 8'h62);
    send_beat(OP_TEXT, 8'h63);
    directed_beats = sent_beats;

    while (sent_beats - directed_beats < RANDOM_BEATS) begin
      drain();
      steady = ($urandom_range(0, 3) == 0);
      pat_len = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 8);
      alpha[0] = rand_sym();
      for (int a = 1; a < 4; a++) alpha[a] = alpha[a-1] + SYM_W'($urandom_range(1, 60));
      for (int i = 0; i < pat_len; i++) begin
        pat_idx[i] = $urandom_range(0, 3);
        pat_opt[i] = ($urandom_range(0, 3) == 0);
        pat_rep[i] = ($urandom_range(0, 4) == 0);
      end
      opt = '0;
      gb  = '0;
      ge  = '0;
      acc = '0;
      for (int i = 0; i < pat_len; i++) begin
        if (pat_opt[i]) begin
          opt[i] = 1'b1;
          if (i > 0 && !pat_opt[i-1]) gb[i-1] = 1'b1;
          if (i == pat_len - 1 || !pat_opt[i+1]) ge[i] = 1'b1;
        end
      end
      acc[pat_len-1] = 1'b1;
      kind = $urandom_range(0, 7);
      case (kind)
        0: load_registers('0, '0, '0, '0);
        1: load_registers('1, '1, '1, '1);
        2: load_registers(rand64(), rand64(), rand64(), rand64());
        default: load_registers(opt, gb, ge, acc);
      endcase
      for (int a = 0; a < 4; a++) begin
        mm = '0;
        rm = '0;
        for (int i = 0; i < pat_len; i++) begin
          if (pat_idx[i] == a) begin
            mm[i] = 1'b1;
            rm[i] = pat_rep[i];
          end
        end
        send_beat(OP_LOAD, alpha[a], mm, rm);
      end
      if ($urandom_range(0, 3) != 0) send_beat(OP_RESTART, rand_sym());
      phase_len = $urandom_range(20, 70);
      phase_start = sent_beats;
      while (sent_beats - phase_start < phase_len) begin
        r = $urandom_range(0, 99);
        if (r < 55)
          emit_instance();
        else if (r < 80)
          send_beat(OP_TEXT, alpha[$urandom_range(0, 3)]);
        else if (r < 88)
          send_beat(OP_TEXT, rand_sym());
        else if (r < 92)
          send_beat(OP_RESTART, rand_sym(), rand64(), rand64());
        else if (r < 95)
          send_beat(OP_NONE, rand_sym(), rand64(), rand64());
        else
          send_beat(OP_LOAD, rand_sym(), rand64(), rand64());
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("extended_shift_and_matcher_unit_tb: clean");
    else
      $display("extended_shift_and_matcher_unit_tb: errors");
    $finish;
  end

endmodule
